// File: rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, constants and helpers of the integer-to-text formatter.
// ----------------------------------------------------------------------------
package itp_pkg;

    // field width saturation and derived counter width
    localparam int MAX_WIDTH = 48;
    localparam int CW        = $clog2(MAX_WIDTH + 1);

    // number geometry
    localparam int VAL_W     = 32;
    localparam int RADIX_W   = 6;
    localparam int FW_W      = 6;
    localparam int PREC_W    = 6;
    localparam int FLAGS_W   = 7;
    localparam int CHAR_W    = 8;
    localparam int MAX_PREC  = 32;

    // digit buffer: one entry per quotient digit, at most one per value bit
    localparam int DIGITS    = 32;
    localparam int DIG_IDX_W = $clog2(DIGITS);
    localparam int ND_W      = $clog2(DIGITS + 1);

    // iterative divider: quotient bits retired per cycle
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = VAL_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // job queue depth
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // format flag bit positions
    localparam int FL_ZERO   = 0;
    localparam int FL_SIGNED = 1;
    localparam int FL_PLUS   = 2;
    localparam int FL_SPACE  = 3;
    localparam int FL_LEFT   = 4;
    localparam int FL_PREFIX = 5;
    localparam int FL_LOWER  = 6;

    // radix codes with special handling
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;

    // sign position content
    typedef enum logic [1:0] {
        SIGN_NONE,
        SIGN_MINUS,
        SIGN_PLUS,
        SIGN_SPACE
    } t_sign;

    // classified job handed from front to back
    typedef struct packed {
        logic [VAL_W-1:0]   mag;
        logic [RADIX_W-1:0] radix;
        logic [CW-1:0]      width;
        logic [PREC_W-1:0]  prec;
        logic               zero;
        logic               left;
        logic               lower;
        t_sign              sign;
        logic [1:0]         pfx_len;
        logic               bad;
    } t_job;

    // divider request and response
    typedef struct packed {
        logic               start;
        logic [VAL_W-1:0]   dividend;
        logic [RADIX_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [VAL_W-1:0]   quot;
        logic [RADIX_W-1:0] rem;
    } t_div_rsp;

    // digit value to ascii, upper or lower case letters
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                     input logic lower);
        logic [CHAR_W-1:0] base;
        base = lower ? CH_LOWER_A : CH_UPPER_A;
        if (d < 6'd10)
            digit_char = CH_ZERO + {2'b00, d};
        else
            digit_char = base + {2'b00, d} - 8'd10;
    endfunction

endpackage

// File: rtl/itp_if.sv
// ----------------------------------------------------------------------------
// itp_in_if / itp_out_if
// Valid/ready channels for number items in and text characters out.
// ----------------------------------------------------------------------------
interface itp_in_if;
    logic                        valid;
    logic                        ready;
    logic [itp_pkg::VAL_W-1:0]   value;
    logic [itp_pkg::RADIX_W-1:0] radix;
    logic [itp_pkg::FW_W-1:0]    text_width;
    logic [itp_pkg::PREC_W-1:0]  min_digits;
    logic [itp_pkg::FLAGS_W-1:0] format_flags;

    modport source (output valid, value, radix, text_width, min_digits, format_flags,
                    input ready);
    modport sink   (input valid, value, radix, text_width, min_digits, format_flags,
                    output ready);
endinterface

interface itp_out_if;
    logic                       valid;
    logic                       ready;
    logic [itp_pkg::CHAR_W-1:0] out_char;
    logic                       last;
    logic                       bad_radix;

    modport source (output valid, out_char, last, bad_radix, input ready);
    modport sink   (input valid, out_char, last, bad_radix, output ready);
endinterface

// File: rtl/itp_front.sv
// ----------------------------------------------------------------------------
// itp_front
// Accepts number items and classifies them: saturation, sign, prefix, radix check.
// ----------------------------------------------------------------------------
module itp_front (
    itp_in_if.sink          i_in,
    output logic            o_job_valid,
    output itp_pkg::t_job   o_job,
    input  logic            i_job_ready
);

    logic [6:0]                  fw_ext;
    logic [itp_pkg::FLAGS_W-1:0] fl;
    logic                        neg;
    logic                        left;

    // handshake passes straight to the queue
    assign o_job_valid = i_in.valid;
    assign i_in.ready  = i_job_ready;

    assign fl     = i_in.format_flags;
    assign left   = fl[itp_pkg::FL_LEFT];
    assign neg    = fl[itp_pkg::FL_SIGNED] & i_in.value[itp_pkg::VAL_W-1];
    assign fw_ext = {1'b0, i_in.text_width};

    // classification
    always_comb begin
        o_job.mag   = neg ? (32'd0 - i_in.value) : i_in.value;
        o_job.radix = i_in.radix;
        if (fw_ext > 7'(itp_pkg::MAX_WIDTH))
            o_job.width = itp_pkg::CW'(itp_pkg::MAX_WIDTH);
        else
            o_job.width = itp_pkg::CW'(fw_ext);
        if (i_in.min_digits > 6'(itp_pkg::MAX_PREC))
            o_job.prec = 6'(itp_pkg::MAX_PREC);
        else
            o_job.prec = i_in.min_digits;
        o_job.zero  = fl[itp_pkg::FL_ZERO] & ~left;
        o_job.left  = left;
        o_job.lower = fl[itp_pkg::FL_LOWER];
        if (neg)
            o_job.sign = itp_pkg::SIGN_MINUS;
        else if (fl[itp_pkg::FL_PLUS])
            o_job.sign = itp_pkg::SIGN_PLUS;
        else if (fl[itp_pkg::FL_SPACE])
            o_job.sign = itp_pkg::SIGN_SPACE;
        else
            o_job.sign = itp_pkg::SIGN_NONE;
        if (fl[itp_pkg::FL_PREFIX] && i_in.radix == itp_pkg::RADIX_HEX)
            o_job.pfx_len = 2'd2;
        else if (fl[itp_pkg::FL_PREFIX] && i_in.radix == itp_pkg::RADIX_OCT)
            o_job.pfx_len = 2'd1;
        else
            o_job.pfx_len = 2'd0;
        o_job.bad = (i_in.radix < itp_pkg::RADIX_MIN) || (i_in.radix > itp_pkg::RADIX_MAX);
    end

endmodule

// File: rtl/itp_queue.sv
// ----------------------------------------------------------------------------
// itp_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module itp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  itp_pkg::t_job   i_push_job,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output itp_pkg::t_job   o_pop_job
);

    itp_pkg::t_job                r_mem [itp_pkg::QDEPTH];
    logic [itp_pkg::QPTR_W-1:0]   r_wr;
    logic [itp_pkg::QPTR_W-1:0]   r_rd;
    logic [itp_pkg::QCNT_W-1:0]   r_count;
    logic                         push;
    logic                         pop;

    assign o_push_ready = (r_count != itp_pkg::QCNT_W'(itp_pkg::QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd];
    assign push         = i_push_valid & o_push_ready;
    assign pop          = o_pop_valid & i_pop_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (push)
            r_mem[r_wr] <= i_push_job;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push)
                r_wr <= (r_wr == itp_pkg::QPTR_W'(itp_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (pop)
                r_rd <= (r_rd == itp_pkg::QPTR_W'(itp_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (push && !pop)
                r_count <= r_count + 1'b1;
            else if (pop && !push)
                r_count <= r_count - 1'b1;
        end
    end

endmodule

// File: rtl/itp_divider.sv
// ----------------------------------------------------------------------------
// itp_divider
// Iterative restoring divider, 32-bit dividend by the radix, 8 bits a cycle.
// ----------------------------------------------------------------------------
module itp_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itp_pkg::t_div_req i_req,
    output itp_pkg::t_div_rsp o_rsp
);

    logic [itp_pkg::VAL_W-1:0]     r_work;
    logic [itp_pkg::RADIX_W-1:0]   r_rem;
    logic [itp_pkg::RADIX_W-1:0]   r_dvs;
    logic [itp_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [itp_pkg::VAL_W-1:0]     n_work;
    logic [itp_pkg::RADIX_W-1:0]   n_rem;

    // one group of restoring steps
    always_comb begin
        logic [itp_pkg::RADIX_W:0] trial;
        n_work = r_work;
        n_rem  = r_rem;
        for (int s = 0; s < itp_pkg::DIV_BITS; s++) begin
            trial  = {n_rem, n_work[itp_pkg::VAL_W-1]};
            n_work = {n_work[itp_pkg::VAL_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                n_rem     = itp_pkg::RADIX_W'(trial - {1'b0, r_dvs});
                n_work[0] = 1'b1;
            end else begin
                n_rem = itp_pkg::RADIX_W'(trial);
            end
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == itp_pkg::DIV_CNT_W'(itp_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_work <= i_req.dividend;
            r_rem  <= '0;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_work;
    assign o_rsp.rem  = r_rem;

endmodule

// File: rtl/itp_back.sv
// ----------------------------------------------------------------------------
// itp_back
// Converts a job to digits, lays out the field and emits it one character a time.
// ----------------------------------------------------------------------------
module itp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  itp_pkg::t_job     i_job,
    output itp_pkg::t_div_req o_div_req,
    input  itp_pkg::t_div_rsp i_div_rsp,
    itp_out_if.source         o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PLAN,
        S_EMIT
    } t_state;

    t_state                         r_state;
    itp_pkg::t_job                  r_job;
    logic [itp_pkg::RADIX_W-1:0]    r_digits [itp_pkg::DIGITS];
    logic [itp_pkg::ND_W-1:0]       r_nd;
    logic                           r_div_start;
    logic [itp_pkg::VAL_W-1:0]      r_dvd;
    logic [itp_pkg::CW-1:0]         r_b1, r_b2, r_b3, r_b5, r_b6, r_total;
    logic [itp_pkg::CW-1:0]         r_pos;
    logic                           r_ovalid;
    logic [itp_pkg::CHAR_W-1:0]     r_char;
    logic                           r_last;
    logic                           r_bad;

    logic [itp_pkg::CW-1:0]         precp, content, pad, p_b1, p_b2, p_b3, p_b4, p_b5, p_b6;
    logic [itp_pkg::CW-1:0]         p_total, nd_ext, dig_off;
    logic [itp_pkg::CHAR_W-1:0]     cur_char, sign_char;
    logic                           out_free;
    logic                           is_last;

    assign o_job_ready = (r_state == S_IDLE);
    assign out_free    = !r_ovalid || o_out.ready;

    assign o_div_req.start    = r_div_start;
    assign o_div_req.dividend = r_dvd;
    assign o_div_req.divisor  = r_job.radix;

    // field layout: region boundaries from digit count and format
    always_comb begin
        nd_ext  = itp_pkg::CW'(r_nd);
        precp   = (nd_ext > itp_pkg::CW'(r_job.prec)) ? nd_ext : itp_pkg::CW'(r_job.prec);
        content = precp + itp_pkg::CW'(r_job.pfx_len)
                + itp_pkg::CW'(r_job.sign != itp_pkg::SIGN_NONE);
        pad     = (r_job.width > content) ? (r_job.width - content) : '0;
        p_b1    = (!r_job.zero && !r_job.left) ? pad : '0;
        p_b2    = p_b1 + itp_pkg::CW'(r_job.sign != itp_pkg::SIGN_NONE);
        p_b3    = p_b2 + itp_pkg::CW'(r_job.pfx_len);
        p_b4    = p_b3 + (r_job.zero ? pad : '0);
        p_b5    = p_b4 + (precp - nd_ext);
        p_b6    = p_b4 + precp;
        p_total = p_b6 + (r_job.left ? pad : '0);
    end

    // sign character
    always_comb begin
        unique case (r_job.sign)
            itp_pkg::SIGN_MINUS: sign_char = itp_pkg::CH_MINUS;
            itp_pkg::SIGN_PLUS:  sign_char = itp_pkg::CH_PLUS;
            itp_pkg::SIGN_SPACE: sign_char = itp_pkg::CH_SPACE;
            itp_pkg::SIGN_NONE:  sign_char = itp_pkg::CH_NUL;
            default:             sign_char = itp_pkg::CH_NUL;
        endcase
    end

    // character at the current position, digits read most significant first
    always_comb begin
        dig_off = r_b6 - r_pos - 1'b1;
        if (r_pos < r_b1)
            cur_char = itp_pkg::CH_SPACE;
        else if (r_pos < r_b2)
            cur_char = sign_char;
        else if (r_pos < r_b3)
            cur_char = (r_pos == r_b2) ? itp_pkg::CH_ZERO
                     : (r_job.lower ? itp_pkg::CH_LOWER_X : itp_pkg::CH_UPPER_X);
        else if (r_pos < r_b5)
            cur_char = itp_pkg::CH_ZERO;
        else if (r_pos < r_b6)
            cur_char = itp_pkg::digit_char(r_digits[dig_off[itp_pkg::DIG_IDX_W-1:0]],
                                           r_job.lower);
        else
            cur_char = itp_pkg::CH_SPACE;
        is_last = (r_pos + 1'b1 == r_total);
    end

    // digit buffer
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && i_div_rsp.done)
            r_digits[r_nd[itp_pkg::DIG_IDX_W-1:0]] <= i_div_rsp.rem;
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_ovalid && o_out.ready)
                r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_dvd <= i_job.mag;
                        r_nd  <= '0;
                        if (i_job.bad) begin
                            r_state <= S_PLAN;
                        end else begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (i_div_rsp.done) begin
                        r_nd <= r_nd + 1'b1;
                        if (i_div_rsp.quot == '0) begin
                            r_state <= S_PLAN;
                        end else begin
                            r_dvd       <= i_div_rsp.quot;
                            r_div_start <= 1'b1;
                        end
                    end
                end
                S_PLAN: begin
                    r_pos <= '0;
                    if (r_job.bad) begin
                        r_b1    <= '0;
                        r_b2    <= '0;
                        r_b3    <= '0;
                        r_b5    <= '0;
                        r_b6    <= '0;
                        r_total <= itp_pkg::CW'(1);
                    end else begin
                        r_b1    <= p_b1;
                        r_b2    <= p_b2;
                        r_b3    <= p_b3;
                        r_b5    <= p_b5;
                        r_b6    <= p_b6;
                        r_total <= p_total;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_char   <= r_job.bad ? itp_pkg::CH_NUL : cur_char;
                        r_last   <= is_last;
                        r_bad    <= r_job.bad;
                        r_pos    <= r_pos + 1'b1;
                        if (is_last)
                            r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.out_char  = r_char;
    assign o_out.last      = r_last;
    assign o_out.bad_radix = r_bad;

endmodule

// File: rtl/integer_to_padded_text.sv
// ----------------------------------------------------------------------------
// integer_to_padded_text
// Formats a 32-bit integer as padded text in radix 2 to 36, one character per item.
// ----------------------------------------------------------------------------
// Each number item comes back as a run of character items, the final one marked
// by last; an invalid radix gives a single item with bad_radix set and char 0.
// The front classifies items and parks up to two in a queue, so the input keeps
// flowing while the back works. The back handles one number at a time: each digit
// takes a start, a load and the groups of 8 quotient bits of the iterative divider,
// then comes a layout step, then one character per cycle when the output is not
// stalled, and a return to idle to take the next job. An invalid radix skips the
// divider and goes straight to the layout step.
// ----------------------------------------------------------------------------
module integer_to_padded_text (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itp_in_if.sink    i_in,
    itp_out_if.source o_out
);

    logic              front_valid;
    logic              front_ready;
    itp_pkg::t_job     front_job;
    logic              job_valid;
    logic              job_ready;
    itp_pkg::t_job     job;
    itp_pkg::t_div_req div_req;
    itp_pkg::t_div_rsp div_rsp;

    // classification
    itp_front u_front (
        .i_in        (i_in),
        .o_job_valid (front_valid),
        .o_job       (front_job),
        .i_job_ready (front_ready)
    );

    // decoupling queue
    itp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_job   (front_job),
        .o_pop_valid  (job_valid),
        .i_pop_ready  (job_ready),
        .o_pop_job    (job)
    );

    // digit extraction
    itp_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // layout and emission
    itp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_out       (o_out)
    );

endmodule

// File: rtl/itp_checker.sv
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks on the character output of the formatter.
// ----------------------------------------------------------------------------
module itp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [itp_pkg::CHAR_W-1:0] i_out_char,
    input logic                       i_out_last,
    input logic                       i_out_bad
);

    // stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
        && $stable(i_out_last) && $stable(i_out_bad))
        else $error("output item changed while stalled");

    // bad radix is a single marked item
    a_bad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_bad |-> i_out_last)
        else $error("bad radix item not marked last");

    // bad radix carries a zero character
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_bad |-> i_out_char == itp_pkg::CH_NUL)
        else $error("bad radix item with nonzero character");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind integer_to_padded_text itp_checker u_itp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_last  (o_out.last),
    .i_out_bad   (o_out.bad_radix)
);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the integer-to-text formatter.
// ----------------------------------------------------------------------------
// Numbers go in on the valid/ready input channel. At each accepted number the
// bench works out the text that should come back and queues one entry per
// character. Every character taken from the output channel is checked field
// by field against the oldest queued entry. The run has directed corner
// cases, a random mix, a long output hold that backs up the input, and a
// final stretch with no idling on either side.
// ----------------------------------------------------------------------------
module tb;

    // flag masks built from the package bit positions
    localparam logic [itp_pkg::FLAGS_W-1:0] F_ZERO   =
        itp_pkg::FLAGS_W'(1 << itp_pkg::FL_ZERO);
    localparam logic [itp_pkg::FLAGS_W-1:0] F_SIGNED =
        itp_pkg::FLAGS_W'(1 << itp_pkg::FL_SIGNED);
    localparam logic [itp_pkg::FLAGS_W-1:0] F_PLUS   =
        itp_pkg::FLAGS_W'(1 << itp_pkg::FL_PLUS);
    localparam logic [itp_pkg::FLAGS_W-1:0] F_SPACE  =
        itp_pkg::FLAGS_W'(1 << itp_pkg::FL_SPACE);
    localparam logic [itp_pkg::FLAGS_W-1:0] F_LEFT   =
        itp_pkg::FLAGS_W'(1 << itp_pkg::FL_LEFT);
    localparam logic [itp_pkg::FLAGS_W-1:0] F_PREFIX =
        itp_pkg::FLAGS_W'(1 << itp_pkg::FL_PREFIX);
    localparam logic [itp_pkg::FLAGS_W-1:0] F_LOWER  =
        itp_pkg::FLAGS_W'(1 << itp_pkg::FL_LOWER);
    localparam logic [itp_pkg::FLAGS_W-1:0] F_ALL    = '1;

    localparam string UPPER_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string LOWER_SET = "0123456789abcdefghijklmnopqrstuvwxyz";

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TICKS = 250;
    localparam int RANDOM_COUNT = 200;
    localparam int STREAM_COUNT = 30;
    localparam int BURST_COUNT  = 12;

    // one character of expected text
    typedef struct {
        logic [itp_pkg::CHAR_W-1:0] ch;
        logic                       last;
        logic                       bad;
    } t_text_char;

    logic i_clk;
    logic i_rst_n;

    itp_in_if  in_ch ();
    itp_out_if out_ch ();

    integer_to_padded_text DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_text_char pending_chars[$];

    int  mismatches         = 0;
    int  numbers_offered    = 0;
    int  chars_compared     = 0;
    int  bad_radix_seen     = 0;
    int  input_stall_cycles = 0;
    int  holds_asked        = 0;
    int  holds_served       = 0;
    bit  idle_on            = 1'b1;
    logic hold_active;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #4000000;
        $display("integer_to_padded_text: mismatch");
        $finish;
    end

    // expected text of one number, queued one character at a time
    function automatic void format_number(input logic [itp_pkg::VAL_W-1:0]   value,
                                          input logic [itp_pkg::RADIX_W-1:0] radix,
                                          input logic [itp_pkg::FW_W-1:0]    fw,
                                          input logic [itp_pkg::PREC_W-1:0]  md,
                                          input logic [itp_pkg::FLAGS_W-1:0] flags);
        int                          width;
        int                          prec;
        int                          pad;
        int                          nd;
        logic [itp_pkg::VAL_W-1:0]   mag;
        logic [itp_pkg::VAL_W-1:0]   base;
        logic [itp_pkg::CHAR_W-1:0]  sign_ch;
        logic [itp_pkg::CHAR_W-1:0]  fill;
        logic [itp_pkg::CHAR_W-1:0]  digit_rev[$];
        logic [itp_pkg::CHAR_W-1:0]  text[$];
        logic [itp_pkg::FLAGS_W-1:0] fl;
        string                       set;

        width = (fw > itp_pkg::MAX_WIDTH) ? itp_pkg::MAX_WIDTH : int'(fw);
        prec  = (md > itp_pkg::MAX_PREC) ? itp_pkg::MAX_PREC : int'(md);
        fl    = flags;
        // left justify cancels zero padding
        if (fl[itp_pkg::FL_LEFT])
            fl[itp_pkg::FL_ZERO] = 1'b0;

        if (radix < itp_pkg::RADIX_MIN || radix > itp_pkg::RADIX_MAX) begin
            pending_chars.push_back('{ch: itp_pkg::CH_NUL, last: 1'b1, bad: 1'b1});
            return;
        end

        set  = fl[itp_pkg::FL_LOWER] ? LOWER_SET : UPPER_SET;
        fill = fl[itp_pkg::FL_ZERO] ? itp_pkg::CH_ZERO : itp_pkg::CH_SPACE;
        mag  = value;
        base = itp_pkg::VAL_W'(radix);

        // sign position: minus beats plus beats space
        sign_ch = itp_pkg::CH_NUL;
        if (fl[itp_pkg::FL_SIGNED] && mag[itp_pkg::VAL_W-1]) begin
            sign_ch = itp_pkg::CH_MINUS;
            mag     = ~mag + 1'b1;
        end else if (fl[itp_pkg::FL_PLUS]) begin
            sign_ch = itp_pkg::CH_PLUS;
        end else if (fl[itp_pkg::FL_SPACE]) begin
            sign_ch = itp_pkg::CH_SPACE;
        end

        pad = width;
        if (sign_ch != itp_pkg::CH_NUL)
            pad--;
        if (fl[itp_pkg::FL_PREFIX] && radix == itp_pkg::RADIX_HEX)
            pad -= 2;
        else if (fl[itp_pkg::FL_PREFIX] && radix == itp_pkg::RADIX_OCT)
            pad -= 1;

        // digits, least significant first; zero gives one digit
        do begin
            digit_rev.push_back(set[int'(mag % base)]);
            mag = mag / base;
        end while (mag != '0);
        nd = digit_rev.size();
        if (nd > prec)
            prec = nd;
        pad -= prec;

        if (!fl[itp_pkg::FL_ZERO] && !fl[itp_pkg::FL_LEFT])
            for (; pad > 0; pad--)
                text.push_back(itp_pkg::CH_SPACE);
        if (sign_ch != itp_pkg::CH_NUL)
            text.push_back(sign_ch);
        if (fl[itp_pkg::FL_PREFIX] && radix == itp_pkg::RADIX_OCT) begin
            text.push_back(itp_pkg::CH_ZERO);
        end else if (fl[itp_pkg::FL_PREFIX] && radix == itp_pkg::RADIX_HEX) begin
            text.push_back(itp_pkg::CH_ZERO);
            text.push_back(fl[itp_pkg::FL_LOWER] ? itp_pkg::CH_LOWER_X
                                                 : itp_pkg::CH_UPPER_X);
        end
        if (!fl[itp_pkg::FL_LEFT])
            for (; pad > 0; pad--)
                text.push_back(fill);
        for (int k = prec - nd; k > 0; k--)
            text.push_back(itp_pkg::CH_ZERO);
        for (int k = nd - 1; k >= 0; k--)
            text.push_back(digit_rev[k]);
        for (; pad > 0; pad--)
            text.push_back(itp_pkg::CH_SPACE);

        foreach (text[i])
            pending_chars.push_back('{ch: text[i], last: (i == text.size() - 1), bad: 1'b0});
    endfunction

    // one mismatch line
    task automatic report_mismatch(input string field, input int got, input int want);
        mismatches++;
        $display("[%0t] char %0d: %s is %0h, expected %0h", $time, chars_compared,
                 field, got, want);
    endtask

    // offer one number and wait for it to be taken
    task automatic offer_number(input logic [itp_pkg::VAL_W-1:0]   value,
                                input logic [itp_pkg::RADIX_W-1:0] radix,
                                input logic [itp_pkg::FW_W-1:0]    fw,
                                input logic [itp_pkg::PREC_W-1:0]  md,
                                input logic [itp_pkg::FLAGS_W-1:0] flags);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.value        <= value;
        in_ch.radix        <= radix;
        in_ch.text_width   <= fw;
        in_ch.min_digits   <= md;
        in_ch.format_flags <= flags;
        do @(posedge i_clk); while (!in_ch.ready);
        format_number(value, radix, fw, md, flags);
        numbers_offered++;
    endtask

    // values biased toward the edges of the 32-bit range
    function automatic logic [itp_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return itp_pkg::VAL_W'($urandom_range(0, 40));
            1: return '1 - itp_pkg::VAL_W'($urandom_range(0, 40));
            2: return {1'b1, {(itp_pkg::VAL_W-1){1'b0}}}
                      + itp_pkg::VAL_W'($urandom_range(0, 40));
            3: return itp_pkg::VAL_W'(1) << $urandom_range(0, itp_pkg::VAL_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // radix: mostly valid, the common bases often, some invalid
    function automatic logic [itp_pkg::RADIX_W-1:0] pick_radix();
        case ($urandom_range(0, 9))
            0: begin
                if ($urandom_range(0, 1))
                    return itp_pkg::RADIX_W'($urandom_range(0, 1));
                return itp_pkg::RADIX_W'($urandom_range(37, 63));
            end
            1: return itp_pkg::RADIX_OCT;
            2: return itp_pkg::RADIX_HEX;
            3: return itp_pkg::RADIX_W'(10);
            default: return itp_pkg::RADIX_W'($urandom_range(2, 36));
        endcase
    endfunction

    // random number with mostly small widths and digit counts
    task automatic offer_random_number();
        logic [itp_pkg::FW_W-1:0]   fw;
        logic [itp_pkg::PREC_W-1:0] md;

        fw = ($urandom_range(0, 7) == 0) ? itp_pkg::FW_W'($urandom_range(0, 63))
                                         : itp_pkg::FW_W'($urandom_range(0, 20));
        md = ($urandom_range(0, 7) == 0) ? itp_pkg::PREC_W'($urandom_range(0, 63))
                                         : itp_pkg::PREC_W'($urandom_range(0, 12));
        offer_number(pick_value(), pick_radix(), fw, md,
                     itp_pkg::FLAGS_W'($urandom_range(0, 127)));
    endtask

    // corner cases of the format
    task automatic test_directed();
        // invalid radix, including all-ones fields
        offer_number(32'd0, 6'd0, 6'd0, 6'd0, '0);
        offer_number(32'd123, 6'd1, 6'd5, 6'd0, '0);
        offer_number(32'd123, 6'd37, 6'd5, 6'd0, F_PLUS);
        offer_number('1, 6'd63, 6'd63, 6'd63, F_ALL);
        // all-ones value in the smallest and the largest radix
        offer_number('1, itp_pkg::RADIX_MIN, 6'd0, 6'd0, '0);
        offer_number('1, itp_pkg::RADIX_MAX, 6'd0, 6'd0, F_LOWER);
        offer_number('1, itp_pkg::RADIX_MAX, 6'd0, 6'd0, '0);
        // most negative signed value
        offer_number(32'h8000_0000, 6'd10, 6'd0, 6'd0, F_SIGNED);
        offer_number(32'h8000_0000, 6'd10, 6'd20, 6'd0, F_SIGNED | F_ZERO);
        // zero still gets its prefix
        offer_number(32'd0, itp_pkg::RADIX_HEX, 6'd0, 6'd0, F_PREFIX);
        offer_number(32'd0, itp_pkg::RADIX_OCT, 6'd6, 6'd0, F_PREFIX | F_ZERO);
        // prefix ignored on other bases
        offer_number(32'd255, 6'd10, 6'd8, 6'd0, F_PREFIX);
        // left cancels zero pad
        offer_number(32'd255, itp_pkg::RADIX_HEX, 6'd10, 6'd4,
                     F_PREFIX | F_LOWER | F_ZERO | F_LEFT);
        // plus wins over space, minus wins over plus
        offer_number(32'd42, 6'd10, 6'd6, 6'd0, F_PLUS | F_SPACE);
        offer_number(32'd42, 6'd10, 6'd6, 6'd0, F_SPACE);
        offer_number(32'hFFFF_FFFE, 6'd10, 6'd5, 6'd0, F_SIGNED | F_PLUS);
        // width and digit count past their limits
        offer_number(32'd7, 6'd10, 6'd63, 6'd0, '0);
        offer_number(32'd7, 6'd10, 6'd0, 6'd63, '0);
        offer_number(32'd7, 6'd10, 6'd63, 6'd63, F_SIGNED | F_PLUS | F_ZERO);
        // text wider than the field, then mixed cases
        offer_number(32'hDEAD_BEEF, itp_pkg::RADIX_HEX, 6'd4, 6'd0, F_PREFIX);
        offer_number(32'd12345, 6'd10, 6'd10, 6'd7, F_LEFT | F_PLUS);
        offer_number(32'd0, 6'd10, 6'd0, 6'd0, '0);
        offer_number(32'd1, itp_pkg::RADIX_MIN, 6'd48, 6'd32, F_ZERO | F_SPACE | F_SIGNED);
        offer_number(32'h7FFF_FFFF, itp_pkg::RADIX_OCT, 6'd20, 6'd12,
                     F_PREFIX | F_PLUS | F_ZERO | F_SIGNED);
        offer_number(32'd35, itp_pkg::RADIX_MAX, 6'd3, 6'd0, F_LOWER | F_LEFT);
    endtask

    // broad random mix with idling on both sides
    task automatic test_random();
        repeat (RANDOM_COUNT) offer_random_number();
    endtask

    // output held off while numbers keep coming, so the input backs up
    task automatic test_backpressure();
        idle_on = 1'b0;
        holds_asked++;
        // nothing on offer while waiting for the hold to begin
        in_ch.valid <= 1'b0;
        while (!hold_active) @(posedge i_clk);
        repeat (BURST_COUNT)
            offer_number(pick_value(), itp_pkg::RADIX_W'($urandom_range(2, 36)),
                         itp_pkg::FW_W'($urandom_range(20, 48)),
                         itp_pkg::PREC_W'($urandom_range(0, 32)),
                         itp_pkg::FLAGS_W'($urandom_range(0, 127)));
        idle_on = 1'b1;
    endtask

    // back to back traffic with no idling anywhere
    task automatic test_streaming();
        idle_on = 1'b0;
        repeat (STREAM_COUNT) offer_random_number();
    endtask

    // output side: random stalls, requested long holds, idle-free when asked
    initial begin
        out_ch.ready <= 1'b0;
        hold_active  <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (holds_served != holds_asked) begin
                holds_served++;
                out_ch.ready <= 1'b0;
                hold_active  <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active  <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // compare each character taken against the oldest expected one
    always @(posedge i_clk) begin : check_chars
        t_text_char want;
        if (i_rst_n && in_ch.valid && !in_ch.ready)
            input_stall_cycles++;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("unexpected out_char", out_ch.out_char, 0);
            end else begin
                want = pending_chars.pop_front();
                if (out_ch.out_char !== want.ch)
                    report_mismatch("out_char", out_ch.out_char, want.ch);
                if (out_ch.last !== want.last)
                    report_mismatch("last", out_ch.last, want.last);
                if (out_ch.bad_radix !== want.bad)
                    report_mismatch("bad_radix", out_ch.bad_radix, want.bad);
                if (want.bad)
                    bad_radix_seen++;
            end
            chars_compared++;
        end
    end

    // stimulus and end of run
    initial begin
        i_rst_n               <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.value           <= '0;
        in_ch.radix           <= '0;
        in_ch.text_width      <= '0;
        in_ch.min_digits      <= '0;
        in_ch.format_flags    <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random();
        test_backpressure();
        test_streaming();

        // drain, then watch for stray characters
        in_ch.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("covered %0d numbers (%0d with a bad radix), %0d characters checked",
                 numbers_offered, bad_radix_seen, chars_compared);
        $display("input held back %0d cycles, including one %0d-cycle output hold",
                 input_stall_cycles, HOLD_CYCLES);
        if (mismatches == 0)
            $display("integer_to_padded_text: match");
        else
            $display("integer_to_padded_text: mismatch");
        $finish;
    end

endmodule
